>>> rtl/edi2d_pkg.sv
// Shared types, constants, saturation helpers and the microcode table of the drag integrator.
`default_nettype none

package edi2d_pkg;

   // Item and result layouts
   typedef struct packed {
      logic               func;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic [15:0]        time_step;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } rsp_payload_type;

   // Item function codes
   localparam logic FUNC_MOVE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Configuration registers
   localparam int unsigned CSR_WIDTH = 31;

   typedef enum logic {
      CSR_MOVE_SPEED     = 1'b0,
      CSR_DRAG_OVER_MASS = 1'b1
   } csr_index_type;

   localparam logic [CSR_WIDTH-1:0] MOVE_SPEED_RESET     = 31'd65536;
   localparam logic [CSR_WIDTH-1:0] DRAG_OVER_MASS_RESET = 31'd0;

   // Square root unit: 64-bit radicand, 32-bit root, two radicand bits per iteration
   localparam int unsigned RADICAND_WIDTH = 64;
   localparam int unsigned ROOT_WIDTH     = RADICAND_WIDTH / 2;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Microcode fields
   typedef enum logic [2:0] {
      A_DIR_X,
      A_DIR_Y,
      A_VEL_X,
      A_VEL_Y,
      A_DRAG,
      A_ACC_X,
      A_ACC_Y
   } mul_a_type;

   typedef enum logic [2:0] {
      B_SPEED,
      B_VEL_X,
      B_VEL_Y,
      B_ROOT,
      B_NEG_K,
      B_DT
   } mul_b_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_VX_SET,
      WB_VY_SET,
      WB_SQ_LOAD,
      WB_SQ_ADD,
      WB_K,
      WB_AX,
      WB_AY,
      WB_VX_ADD,
      WB_VY_ADD,
      WB_PX_ADD,
      WB_PY_ADD
   } wb_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_INIT,
      SQ_STEP
   } sqrt_op_type;

   typedef enum logic [1:0] {
      J_NONE,
      J_ALWAYS,
      J_VEL_ZERO,
      J_SQRT_BUSY
   } jump_type;

   localparam int unsigned STEP_COUNT = 18;
   localparam int unsigned PC_WIDTH   = $clog2(STEP_COUNT);
   typedef logic [PC_WIDTH-1:0] pc_type;

   // Step addresses
   localparam pc_type S_MOVE_DX   = 5'd0;
   localparam pc_type S_MOVE_DY   = 5'd1;
   localparam pc_type S_MOVE_VY   = 5'd2;
   localparam pc_type S_TICK_VX2  = 5'd3;
   localparam pc_type S_TICK_VY2  = 5'd4;
   localparam pc_type S_SQ_ADD    = 5'd5;
   localparam pc_type S_SQRT_INIT = 5'd6;
   localparam pc_type S_SQRT_LOOP = 5'd7;
   localparam pc_type S_K_MUL     = 5'd8;
   localparam pc_type S_K_WB      = 5'd9;
   localparam pc_type S_AX_MUL    = 5'd10;
   localparam pc_type S_AY_MUL    = 5'd11;
   localparam pc_type S_DVX_MUL   = 5'd12;
   localparam pc_type S_DVY_MUL   = 5'd13;
   localparam pc_type S_DPX_MUL   = 5'd14;
   localparam pc_type S_DPY_MUL   = 5'd15;
   localparam pc_type S_PY_WB     = 5'd16;
   localparam pc_type S_DONE      = 5'd17;

   typedef struct packed {
      mul_a_type   mul_a;
      mul_b_type   mul_b;
      wb_type      wb;
      sqrt_op_type sqrt_op;
      jump_type    jump;
      pc_type      target;
      logic        done;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_NOP = '{
      mul_a: A_DIR_X, mul_b: B_SPEED, wb: WB_NONE, sqrt_op: SQ_IDLE,
      jump: J_NONE, target: S_MOVE_DX, done: 1'b0
   };

   typedef struct packed {
      logic vel_zero;
      logic sqrt_busy;
   } dp_status_type;

   // Clamp a value to the signed 32-bit range
   function automatic logic signed [31:0] sat_s50(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v[49:31] == '0 || v[49:31] == '1) begin
         r = v[31:0];
      end else begin
         r = v[49] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   // Saturating signed 32-bit add
   function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      logic signed [32:0] s;
      logic signed [31:0] r;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         r = s[32] ? S32_MIN : S32_MAX;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic ctrl_word_type cw(input mul_a_type a, input mul_b_type b,
                                        input wb_type w, input sqrt_op_type q,
                                        input jump_type j, input pc_type t,
                                        input logic d);
      ctrl_word_type c;
      c = '{mul_a: a, mul_b: b, wb: w, sqrt_op: q, jump: j, target: t, done: d};
      return c;
   endfunction

   // Microcode table. A product issued in one step is written back in the next.
   function automatic ctrl_word_type microcode(input pc_type addr);
      ctrl_word_type w;
      unique case (addr)
         // move: v = dir * move_speed
         S_MOVE_DX:   w = cw(A_DIR_X, B_SPEED, WB_NONE, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_MOVE_DY:   w = cw(A_DIR_Y, B_SPEED, WB_VX_SET, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_MOVE_VY:   w = cw(A_DIR_X, B_SPEED, WB_VY_SET, SQ_IDLE, J_ALWAYS, S_DONE, 1'b0);
         // tick: squared speed, skipped when at rest
         S_TICK_VX2:  w = cw(A_VEL_X, B_VEL_X, WB_NONE, SQ_IDLE, J_VEL_ZERO, S_DONE, 1'b0);
         S_TICK_VY2:  w = cw(A_VEL_Y, B_VEL_Y, WB_SQ_LOAD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_SQ_ADD:    w = cw(A_DIR_X, B_SPEED, WB_SQ_ADD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         // square root, one root bit per pass
         S_SQRT_INIT: w = cw(A_DIR_X, B_SPEED, WB_NONE, SQ_INIT, J_NONE, S_MOVE_DX, 1'b0);
         S_SQRT_LOOP: w = cw(A_DIR_X, B_SPEED, WB_NONE, SQ_STEP, J_SQRT_BUSY, S_SQRT_LOOP,
                             1'b0);
         // drag factor and acceleration
         S_K_MUL:     w = cw(A_DRAG, B_ROOT, WB_NONE, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_K_WB:      w = cw(A_DIR_X, B_SPEED, WB_K, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_AX_MUL:    w = cw(A_VEL_X, B_NEG_K, WB_NONE, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_AY_MUL:    w = cw(A_VEL_Y, B_NEG_K, WB_AX, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         // Euler updates, velocity first
         S_DVX_MUL:   w = cw(A_ACC_X, B_DT, WB_AY, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_DVY_MUL:   w = cw(A_ACC_Y, B_DT, WB_VX_ADD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_DPX_MUL:   w = cw(A_VEL_X, B_DT, WB_VY_ADD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_DPY_MUL:   w = cw(A_VEL_Y, B_DT, WB_PX_ADD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_PY_WB:     w = cw(A_DIR_X, B_SPEED, WB_PY_ADD, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b0);
         S_DONE:      w = cw(A_DIR_X, B_SPEED, WB_NONE, SQ_IDLE, J_NONE, S_MOVE_DX, 1'b1);
         default:     w = CTRL_NOP;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/edi2d_isqrt.sv
// Iterative integer square root, two radicand bits per cycle while op is SQ_STEP.
`default_nettype none

module edi2d_isqrt (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire edi2d_pkg::sqrt_op_type                op,
   input  wire logic [edi2d_pkg::RADICAND_WIDTH-1:0]  radicand,
   output logic      [edi2d_pkg::ROOT_WIDTH-1:0]      root,
   output logic                                       busy
);

   localparam int unsigned RW = edi2d_pkg::ROOT_WIDTH;
   localparam int unsigned XW = edi2d_pkg::RADICAND_WIDTH;
   localparam int unsigned CW = $clog2(RW);
   localparam logic [CW-1:0] LAST_ITER = CW'(RW - 1);

   logic [XW-1:0] x_ff;
   logic [RW:0]   rem_ff;
   logic [RW-1:0] root_ff;
   logic [CW-1:0] count_ff;

   logic [RW+2:0] cand;
   logic [RW+2:0] trial;
   logic [RW+2:0] diff;
   logic          fits;

   // One restoring step: bring down two bits, try root*4+1
   always_comb begin
      cand  = {rem_ff, x_ff[XW-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      diff  = cand - trial;
      fits  = (cand >= trial);
   end

   // Iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op == edi2d_pkg::SQ_INIT) begin
         count_ff <= LAST_ITER;
      end else if (op == edi2d_pkg::SQ_STEP && count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   // Partial remainder and root
   always_ff @(posedge clock) begin
      if (op == edi2d_pkg::SQ_INIT) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (op == edi2d_pkg::SQ_STEP) begin
         x_ff <= {x_ff[XW-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= diff[RW:0];
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= cand[RW:0];
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff;
   assign busy = (count_ff != '0);

endmodule

`default_nettype wire

>>> rtl/edi2d_datapath.sv
// Datapath: state registers, shared multiplier, write-back logic and square root unit.
`default_nettype none

module edi2d_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire edi2d_pkg::req_payload_type      req_payload,
   input  wire edi2d_pkg::ctrl_word_type        ctrl,
   input  wire logic [edi2d_pkg::CSR_WIDTH-1:0] move_speed,
   input  wire logic [edi2d_pkg::CSR_WIDTH-1:0] drag_over_mass,
   output edi2d_pkg::rsp_payload_type           state,
   output edi2d_pkg::dp_status_type             status
);

   localparam int unsigned RW = edi2d_pkg::ROOT_WIDTH;
   localparam int unsigned XW = edi2d_pkg::RADICAND_WIDTH;

   // Captured item
   logic signed [31:0] dir_x_ff;
   logic signed [31:0] dir_y_ff;
   logic [15:0]        dt_ff;

   // Body state
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic signed [31:0] vel_x_ff;
   logic signed [31:0] vel_y_ff;

   // Intermediates
   logic signed [65:0] prod_ff;
   logic [XW-1:0]      sq_ff;
   logic [31:0]        k_ff;
   logic signed [31:0] acc_x_ff;
   logic signed [31:0] acc_y_ff;

   logic signed [32:0] mul_a_op;
   logic signed [32:0] mul_b_op;
   logic signed [65:0] prod_in;
   logic signed [32:0] neg_k;
   logic signed [31:0] fx;
   logic               k_over;
   logic [31:0]        k_in;
   logic [RW-1:0]      root;
   logic               sqrt_busy;

   edi2d_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .op       (ctrl.sqrt_op),
      .radicand (sq_ff),
      .root     (root),
      .busy     (sqrt_busy)
   );

   // Operand selection for the shared 33x33 multiplier
   always_comb begin
      neg_k = 33'sd0 - $signed({1'b0, k_ff});
      unique case (ctrl.mul_a)
         edi2d_pkg::A_DIR_X: mul_a_op = {dir_x_ff[31], dir_x_ff};
         edi2d_pkg::A_DIR_Y: mul_a_op = {dir_y_ff[31], dir_y_ff};
         edi2d_pkg::A_VEL_X: mul_a_op = {vel_x_ff[31], vel_x_ff};
         edi2d_pkg::A_VEL_Y: mul_a_op = {vel_y_ff[31], vel_y_ff};
         edi2d_pkg::A_DRAG:  mul_a_op = {2'b00, drag_over_mass};
         edi2d_pkg::A_ACC_X: mul_a_op = {acc_x_ff[31], acc_x_ff};
         edi2d_pkg::A_ACC_Y: mul_a_op = {acc_y_ff[31], acc_y_ff};
         default:            mul_a_op = '0;
      endcase
      unique case (ctrl.mul_b)
         edi2d_pkg::B_SPEED: mul_b_op = {2'b00, move_speed};
         edi2d_pkg::B_VEL_X: mul_b_op = {vel_x_ff[31], vel_x_ff};
         edi2d_pkg::B_VEL_Y: mul_b_op = {vel_y_ff[31], vel_y_ff};
         edi2d_pkg::B_ROOT:  mul_b_op = {1'b0, root};
         edi2d_pkg::B_NEG_K: mul_b_op = neg_k;
         edi2d_pkg::B_DT:    mul_b_op = {17'd0, dt_ff};
         default:            mul_b_op = '0;
      endcase
      prod_in = mul_a_op * mul_b_op;
   end

   // Q16.16 product: floor shift by 16 then clamp; drag factor capped at 2^31
   always_comb begin
      fx     = edi2d_pkg::sat_s50(prod_ff[65:16]);
      k_over = (prod_ff[65:48] != '0) || (prod_ff[47] && prod_ff[46:16] != '0);
      k_in   = k_over ? 32'h8000_0000 : prod_ff[47:16];
   end

   // Body state, written back from the previous step's product
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
      end else begin
         unique case (ctrl.wb)
            edi2d_pkg::WB_VX_SET: vel_x_ff <= fx;
            edi2d_pkg::WB_VY_SET: vel_y_ff <= fx;
            edi2d_pkg::WB_VX_ADD: vel_x_ff <= edi2d_pkg::sat_add32(vel_x_ff, fx);
            edi2d_pkg::WB_VY_ADD: vel_y_ff <= edi2d_pkg::sat_add32(vel_y_ff, fx);
            edi2d_pkg::WB_PX_ADD: pos_x_ff <= edi2d_pkg::sat_add32(pos_x_ff, fx);
            edi2d_pkg::WB_PY_ADD: pos_y_ff <= edi2d_pkg::sat_add32(pos_y_ff, fx);
            default: ;
         endcase
      end
   end

   // Item capture, product register and intermediates
   always_ff @(posedge clock) begin
      if (load) begin
         dir_x_ff <= req_payload.dir_x;
         dir_y_ff <= req_payload.dir_y;
         dt_ff    <= req_payload.time_step;
      end
      prod_ff <= prod_in;
      unique case (ctrl.wb)
         edi2d_pkg::WB_SQ_LOAD: sq_ff    <= prod_ff[XW-1:0];
         edi2d_pkg::WB_SQ_ADD:  sq_ff    <= sq_ff + prod_ff[XW-1:0];
         edi2d_pkg::WB_K:       k_ff     <= k_in;
         edi2d_pkg::WB_AX:      acc_x_ff <= fx;
         edi2d_pkg::WB_AY:      acc_y_ff <= fx;
         default: ;
      endcase
   end

   assign state = '{pos_x: pos_x_ff, pos_y: pos_y_ff, vel_x: vel_x_ff, vel_y: vel_y_ff};
   assign status = '{vel_zero: (vel_x_ff == '0 && vel_y_ff == '0), sqrt_busy: sqrt_busy};

endmodule

`default_nettype wire

>>> rtl/euler_drag_integrator_2d.sv
// Top level: configuration registers, microcode sequencer and result register.
//
// Usage: a 2D body under quadratic drag, stepped by semi-implicit Euler in Q16.16.
// Items arrive on req_* (valid/stall); an item transfers when req_valid is
// high and req_stall is low. func selects move (set velocity from direction)
// or tick (drag and Euler update over time_step). Every item gives exactly one
// result on rsp_* carrying position and velocity after the item.
// Configuration is a plain write port: csr_write with csr_index and csr_data.
// The square root loop, one pass per bit of the 32-bit root, dominates a
// tick; every other step is one pass of the shared 33x33 multiplier. A tick
// at zero velocity skips straight to the final step. One item is worked on
// at a time: a new item is not taken until the last one has left its final step.
// req_stall is high while an item is in work. A finished result waits in the
// output register; a stalled receiver holds it and the next item can still be
// taken, but its result waits at the final step until the register frees up.
// Reset clears position and velocity to zero, move_speed to 1.0 and
// drag_over_mass to zero, and empties the result register.
`default_nettype none

module euler_drag_integrator_2d (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire edi2d_pkg::req_payload_type      req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output edi2d_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                            csr_write,
   input  wire edi2d_pkg::csr_index_type        csr_index,
   input  wire logic [edi2d_pkg::CSR_WIDTH-1:0] csr_data
);

   logic [edi2d_pkg::CSR_WIDTH-1:0] move_speed_ff;
   logic [edi2d_pkg::CSR_WIDTH-1:0] drag_over_mass_ff;

   logic                        busy_ff;
   edi2d_pkg::pc_type           pc_ff;
   edi2d_pkg::pc_type           pc_in;
   logic                        rsp_valid_ff;
   edi2d_pkg::rsp_payload_type  rsp_payload_ff;

   edi2d_pkg::ctrl_word_type    rom_word;
   edi2d_pkg::ctrl_word_type    ctrl;
   edi2d_pkg::rsp_payload_type  dp_state;
   edi2d_pkg::dp_status_type    dp_status;
   logic                        req_xfer;
   logic                        done_fire;
   logic                        taken;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         move_speed_ff     <= edi2d_pkg::MOVE_SPEED_RESET;
         drag_over_mass_ff <= edi2d_pkg::DRAG_OVER_MASS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            edi2d_pkg::CSR_MOVE_SPEED:     move_speed_ff     <= csr_data;
            edi2d_pkg::CSR_DRAG_OVER_MASS: drag_over_mass_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Microcode fetch and branch decision
   always_comb begin
      rom_word  = edi2d_pkg::microcode(pc_ff);
      ctrl      = busy_ff ? rom_word : edi2d_pkg::CTRL_NOP;
      req_xfer  = req_valid && !req_stall;
      done_fire = busy_ff && rom_word.done && !(rsp_valid_ff && rsp_stall);
      unique case (rom_word.jump)
         edi2d_pkg::J_NONE:      taken = 1'b0;
         edi2d_pkg::J_ALWAYS:    taken = 1'b1;
         edi2d_pkg::J_VEL_ZERO:  taken = dp_status.vel_zero;
         edi2d_pkg::J_SQRT_BUSY: taken = dp_status.sqrt_busy;
         default:                taken = 1'b0;
      endcase
      priority if (req_xfer) begin
         pc_in = (req_payload.func == edi2d_pkg::FUNC_TICK) ? edi2d_pkg::S_TICK_VX2
                                                            : edi2d_pkg::S_MOVE_DX;
      end else if (!busy_ff || rom_word.done) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = rom_word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // Sequencer and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= edi2d_pkg::S_MOVE_DX;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (done_fire) begin
            busy_ff <= 1'b0;
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_payload_ff <= dp_state;
      end
   end

   edi2d_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .load           (req_xfer),
      .req_payload    (req_payload),
      .ctrl           (ctrl),
      .move_speed     (move_speed_ff),
      .drag_over_mass (drag_over_mass_ff),
      .state          (dp_state),
      .status         (dp_status)
   );

   assign req_stall   = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // An accepted item always starts the sequencer
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> busy_ff)
      else $error("accepted item did not start the sequencer");

   // A result appears only from the final step
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done_fire))
      else $error("result raised without a completed item");

   // The square root unit only runs inside the root loop
   a_sqrt_in_loop: assert property (@(posedge clock) disable iff (reset)
      dp_status.sqrt_busy |-> (busy_ff && pc_ff == edi2d_pkg::S_SQRT_LOOP))
      else $error("square root running outside its loop step");
`endif

endmodule

`default_nettype wire

>>> tb/tb_euler_drag_integrator_2d.sv
// Self-checking bench for the 2D drag integrator: item driver, result monitor, body predictor.
module tb_euler_drag_integrator_2d;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [edi2d_pkg::CSR_WIDTH-1:0] csr_data_type;

   localparam int   CYCLE_LIMIT = 800_000;
   localparam int   END_SETTLE  = 50;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   edi2d_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   edi2d_pkg::rsp_payload_type rsp_payload;
   logic                       csr_write = 1'b0;
   edi2d_pkg::csr_index_type   csr_index = edi2d_pkg::CSR_MOVE_SPEED;
   csr_data_type               csr_data = '0;

   euler_drag_integrator_2d DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Items waiting to be sent, and body states waiting to be reported
   edi2d_pkg::req_payload_type items_to_send[$];
   edi2d_pkg::rsp_payload_type body_states_due[$];

   // Shadow of the body and its registers
   logic signed [31:0]   body_px, body_py, body_vx, body_vy;
   csr_data_type         speed_q, drag_q;

   int  cycle_count    = 0;
   int  fail_count     = 0;
   int  results_seen   = 0;
   int  move_count     = 0;
   int  tick_count     = 0;
   int  rest_ticks     = 0;
   int  settings_count = 0;
   bit  req_xfer       = 1'b0;
   bit  quiet_phase    = 1'b0;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Q16.16 product, floored and clamped to 32 bits
   function automatic logic signed [31:0] q_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [127:0] p;
      logic signed [31:0]  r;
      p = a * b;
      p = p >>> 16;
      if (p > 128'sh7FFF_FFFF) begin
         r = edi2d_pkg::S32_MAX;
      end else if (p < -128'sh8000_0000) begin
         r = edi2d_pkg::S32_MIN;
      end else begin
         r = p[31:0];
      end
      return r;
   endfunction

   // Clamped 32-bit sum
   function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      logic signed [31:0] r;
      s = a + b;
      if (s > 33'sh0_7FFF_FFFF) begin
         r = edi2d_pkg::S32_MAX;
      end else if (s < -33'sh0_8000_0000) begin
         r = edi2d_pkg::S32_MIN;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // Integer square root, floored, two radicand bits per pass
   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] rem, res, bitv;
      rem  = x;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Apply one item to the shadow body and return the state it reports
   function automatic edi2d_pkg::rsp_payload_type advance_body(
      input edi2d_pkg::req_payload_type item);
      logic signed [63:0]         vx, vy, dt, neg_k;
      logic [63:0]                sq, speed, k;
      logic signed [31:0]         ax, ay;
      edi2d_pkg::rsp_payload_type r;
      dt = {48'd0, item.time_step};
      if (item.func == edi2d_pkg::FUNC_MOVE) begin
         move_count++;
         body_vx = q_mul({{32{item.dir_x[31]}}, item.dir_x}, {33'd0, speed_q});
         body_vy = q_mul({{32{item.dir_y[31]}}, item.dir_y}, {33'd0, speed_q});
      end else if (body_vx == 0 && body_vy == 0) begin
         // body at rest: nothing moves
         tick_count++;
         rest_ticks++;
      end else begin
         tick_count++;
         vx    = body_vx;
         vy    = body_vy;
         sq    = 64'(vx * vx) + 64'(vy * vy);
         speed = root_floor(sq);
         k     = ({33'd0, drag_q} * speed) >> 16;
         if (k > 64'h8000_0000) k = 64'h8000_0000;
         neg_k = -$signed(k);
         ax    = q_mul(vx, neg_k);
         ay    = q_mul(vy, neg_k);
         // velocity first, then position from the new velocity
         body_vx = sat_sum(body_vx, q_mul({{32{ax[31]}}, ax}, dt));
         body_vy = sat_sum(body_vy, q_mul({{32{ay[31]}}, ay}, dt));
         body_px = sat_sum(body_px, q_mul({{32{body_vx[31]}}, body_vx}, dt));
         body_py = sat_sum(body_py, q_mul({{32{body_vy[31]}}, body_vy}, dt));
      end
      r.pos_x = body_px;
      r.pos_y = body_py;
      r.vel_x = body_vx;
      r.vel_y = body_vy;
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_dir();
      int          r;
      logic [31:0] mag;
      r = $urandom_range(0, 99);
      if (r < 25) return $urandom;
      if (r < 70) mag = $urandom_range(0, 4 << 16);
      else if (r < 85) mag = $urandom_range(0, 255);
      else if (r < 90) return 32'h7FFF_FFFF;
      else if (r < 95) return 32'h8000_0000;
      else return 32'h0;
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [15:0] rand_dt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 16'($urandom_range(0, 16'h2000));
      if (r < 80) return 16'($urandom);
      if (r < 90) return 16'h0000;
      return 16'hFFFF;
   endfunction

   // Item driver: next item presented after the previous transfer and any gap
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (items_to_send.size() > 0) begin
            req_payload <= items_to_send.pop_front();
            req_valid   <= 1'b1;
            gap_left     = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin : rsp_backpressure
      int g;
      int stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         g          = pick_gap();
         stall_left = (g > 0) ? g - 1 : 0;
         rsp_stall <= (g > 0);
      end
   end

   // Monitor: check results, predict on item transfer, track register writes
   always @(posedge clock) begin : monitor
      edi2d_pkg::rsp_payload_type due;
      cycle_count++;
      if (reset) begin
         req_xfer = 1'b0;
         body_px  = '0;
         body_py  = '0;
         body_vx  = '0;
         body_vy  = '0;
         speed_q  = edi2d_pkg::MOVE_SPEED_RESET;
         drag_q   = edi2d_pkg::DRAG_OVER_MASS_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (body_states_due.size() == 0) begin
               $error("result transfer with nothing outstanding: %p", rsp_payload);
               fail_count++;
            end else begin
               due = body_states_due.pop_front();
               if (rsp_payload.pos_x !== due.pos_x) begin
                  $error("pos_x: expected %0d, actual %0d", due.pos_x, rsp_payload.pos_x);
                  fail_count++;
               end
               if (rsp_payload.pos_y !== due.pos_y) begin
                  $error("pos_y: expected %0d, actual %0d", due.pos_y, rsp_payload.pos_y);
                  fail_count++;
               end
               if (rsp_payload.vel_x !== due.vel_x) begin
                  $error("vel_x: expected %0d, actual %0d", due.vel_x, rsp_payload.vel_x);
                  fail_count++;
               end
               if (rsp_payload.vel_y !== due.vel_y) begin
                  $error("vel_y: expected %0d, actual %0d", due.vel_y, rsp_payload.vel_y);
                  fail_count++;
               end
            end
         end
         req_xfer = req_valid && !req_stall;
         if (req_xfer) body_states_due.push_back(advance_body(req_payload));
         if (csr_write) begin
            if (csr_index == edi2d_pkg::CSR_MOVE_SPEED) speed_q = csr_data;
            else if (csr_index == edi2d_pkg::CSR_DRAG_OVER_MASS) drag_q = csr_data;
         end
      end
   end

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   task automatic add_item(input logic f, input logic [31:0] dx, input logic [31:0] dy,
                           input logic [15:0] dt);
      edi2d_pkg::req_payload_type it;
      it.func      = f;
      it.dir_x     = dx;
      it.dir_y     = dy;
      it.time_step = dt;
      items_to_send.push_back(it);
   endtask

   task automatic write_reg(input edi2d_pkg::csr_index_type idx, input csr_data_type val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_setting(input csr_data_type spd, input csr_data_type drg);
      write_reg(edi2d_pkg::CSR_MOVE_SPEED, spd);
      write_reg(edi2d_pkg::CSR_DRAG_OVER_MASS, drg);
      settings_count++;
   endtask

   // Hold off until every item has transferred and every result has come back
   task automatic settle_body();
      while (items_to_send.size() != 0 || req_valid || body_states_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly a move followed by a run of ticks, the rest loose items
   task automatic run_random_phase(input csr_data_type spd, input csr_data_type drg,
                                   input int n, input bit quiet);
      int made;
      int ticks;
      made = 0;
      write_setting(spd, drg);
      quiet_phase = quiet;
      while (made < n) begin
         if ($urandom_range(0, 99) < 85) begin
            add_item(edi2d_pkg::FUNC_MOVE, rand_dir(), rand_dir(), 16'($urandom));
            ticks = $urandom_range(1, 8);
            repeat (ticks) add_item(edi2d_pkg::FUNC_TICK, $urandom, $urandom, rand_dt());
            made += ticks + 1;
         end else begin
            add_item(1'($urandom_range(0, 1)), rand_dir(), rand_dir(), rand_dt());
            made++;
         end
      end
      settle_body();
      quiet_phase = 1'b0;
   endtask

   function automatic csr_data_type rand_speed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return csr_data_type'($urandom);
      if (r < 80) return csr_data_type'($urandom_range(0, 4 << 16));
      if (r < 90) return '0;
      return '1;
   endfunction

   function automatic csr_data_type rand_drag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return csr_data_type'($urandom_range(0, 16'h4000));
      if (r < 70) return csr_data_type'($urandom);
      if (r < 85) return '0;
      return '1;
   endfunction

   // Stimulus
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: at rest, zero step, unit move, extremes, position clamping
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h0001_0000, 32'hFFFE_0000, 16'h1234);
      add_item(edi2d_pkg::FUNC_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'h8000);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_MOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'h0001);
      settle_body();

      // Largest speed and drag: saturated products and capped drag factor
      write_setting('1, '1);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h0001_0000, 32'h0001_0000, 16'h0);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'h0001);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_MOVE, 32'hFFFF_0000, 32'h0000_8000, 16'h0);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'h0100);
      settle_body();

      // Zero speed: a move stops the body
      write_setting('0, 31'h0001_0000);
      add_item(edi2d_pkg::FUNC_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      add_item(edi2d_pkg::FUNC_TICK, 32'h0, 32'h0, 16'hFFFF);
      settle_body();

      // Random phases over a spread of settings
      run_random_phase('1, '1, 120, 1'b0);
      run_random_phase('0, '1, 40, 1'b0);
      run_random_phase(31'h0001_0000, 31'h0000_0100, 130, 1'b1);
      run_random_phase(edi2d_pkg::MOVE_SPEED_RESET, edi2d_pkg::DRAG_OVER_MASS_RESET, 130,
                       1'b0);
      repeat (5) run_random_phase(rand_speed(), rand_drag(), 130, 1'b0);

      settle_body();
      repeat (END_SETTLE) @(posedge clock);
      $display("summary: %0d results checked, %0d moves, %0d ticks (%0d at rest)",
               results_seen, move_count, tick_count, rest_ticks);
      $display("summary: %0d register settings, %0d mismatches", settings_count, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
